### rtl/iqsc_pkg.sv
// Package with the shared constants, codes and control types of the index queue.
`default_nettype none
package iqsc_pkg;

  localparam int CAP_LOG2  = 10;
  localparam int DEPTH     = 1 << CAP_LOG2;
  localparam int PTR_W     = CAP_LOG2 + 1;
  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int FAIL_W    = 31;
  localparam int PROD_W    = CAP_LOG2 + SIZE_W;
  localparam int DIV_CNT_W = $clog2(ADDR_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [FAIL_W-1:0]    FAIL_MAX     = {FAIL_W{1'b1}};
  localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(ADDR_W - 1);

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_GET     = 2'd1;
  localparam logic [1:0] KIND_ADD_DEC = 2'd2;
  localparam logic [1:0] KIND_GET_INC = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_BYTES  = 1'd1;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_BAD_ADDR = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_GET,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic add_commit;
    logic get_issue;
    logic mul;
    logic sum;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic empty;
  } sts_t;

endpackage
`default_nettype wire

### rtl/index_queue_with_stall_count.sv
// Top level of the index queue with its count of failed gets.
`default_nettype none
// A FIFO of pool entry indices with a saturating count of failed gets. An add
// takes one beat and its result beat is registered once the entry offset has been
// divided by the entry size in a radix-2 restoring divider, one quotient bit per
// cycle, and the index has been checked and pushed. A get has its result
// registered after the ring read, a registered multiply by the entry size and
// the add of the base address; an empty queue skips the multiply and the add.
// The block works on one item at a time and takes the next item in the cycle
// after a result is registered. It accepts the next item while a result beat
// still waits to be taken; a new result that finds the previous beat still held
// off waits in the last step until that beat is taken. The ring memory needs no
// clearing pass after reset.
module index_queue_with_stall_count
  import iqsc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_kind,
  input  wire logic [ADDR_W-1:0]    in_entry_address,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_status,
  output logic [ADDR_W-1:0]         out_result_address,
  output logic                      out_had_fails
);

  cmd_t cmd;
  sts_t sts;

  iqsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  iqsc_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_kind            (in_kind),
    .in_entry_address   (in_entry_address),
    .cmd                (cmd),
    .sts                (sts),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_had_fails      (out_had_fails)
  );

endmodule
`default_nettype wire

### rtl/iqsc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module iqsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/iqsc_datapath.sv
// Datapath of the index queue: configuration, divider, ring, pointers, fail count.
`default_nettype none
module iqsc_datapath
  import iqsc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  input  wire logic [1:0]           in_kind,
  input  wire logic [ADDR_W-1:0]    in_entry_address,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  output logic [1:0]                out_status,
  output logic [ADDR_W-1:0]         out_result_address,
  output logic                      out_had_fails
);

  logic [ADDR_W-1:0]   base_r;
  logic [SIZE_W-1:0]   size_r;
  logic [SIZE_W-1:0]   eff_size;
  logic [1:0]          kind_r;
  logic                below_r;
  logic [ADDR_W-1:0]   dvd_r;
  logic [SIZE_W-1:0]   rem_r;
  logic [SIZE_W:0]     trial;
  logic                fits;
  logic [PTR_W-1:0]    tail_r;
  logic [PTR_W-1:0]    head_r;
  logic [FAIL_W-1:0]   fail_r;
  logic [PROD_W-1:0]   prod_r;
  status_t             res_status_r;
  logic [ADDR_W-1:0]   res_addr_r;
  logic                res_had_r;
  logic                full;
  logic                bad_index;
  logic                ram_we;
  logic                ram_re;
  logic [CAP_LOG2-1:0] ram_rdata;

  assign eff_size  = (size_r == '0) ? SIZE_W'(1) : size_r;
  assign trial     = {rem_r, dvd_r[ADDR_W-1]};
  assign fits      = (trial >= {1'b0, eff_size});
  assign sts.empty = (tail_r == head_r);
  assign full      = (tail_r[PTR_W-1] != head_r[PTR_W-1]) &&
                     (tail_r[CAP_LOG2-1:0] == head_r[CAP_LOG2-1:0]);
  assign bad_index = below_r || (dvd_r[ADDR_W-1:CAP_LOG2] != '0);
  assign ram_we    = cmd.add_commit && !bad_index && !full;
  assign ram_re    = cmd.get_issue && !sts.empty;

  iqsc_ram #(
    .WIDTH (CAP_LOG2),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tail_r[CAP_LOG2-1:0]),
    .wr_data (dvd_r[CAP_LOG2-1:0]),
    .rd_en   (ram_re),
    .rd_addr (head_r[CAP_LOG2-1:0]),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= SIZE_W'(1);
      tail_r <= '0;
      head_r <= '0;
      fail_r <= '0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_BASE_ADDRESS: base_r <= cfg_data;
          REG_ENTRY_BYTES:  size_r <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (ram_we) begin
        tail_r <= tail_r + PTR_W'(1);
        if (kind_r == KIND_ADD_DEC && fail_r != '0) begin
          fail_r <= fail_r - FAIL_W'(1);
        end
      end
      if (cmd.get_issue) begin
        if (sts.empty) begin
          if (kind_r == KIND_GET_INC && fail_r != FAIL_MAX) begin
            fail_r <= fail_r + FAIL_W'(1);
          end
        end else begin
          head_r <= head_r + PTR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r       <= in_kind;
      below_r      <= (in_entry_address < base_r);
      dvd_r        <= in_entry_address - base_r;
      rem_r        <= '0;
      res_status_r <= STATUS_DONE;
      res_addr_r   <= '0;
      res_had_r    <= 1'b0;
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[ADDR_W-2:0], fits};
      rem_r <= fits ? SIZE_W'(trial - {1'b0, eff_size}) : trial[SIZE_W-1:0];
    end
    if (cmd.add_commit) begin
      if (bad_index) begin
        res_status_r <= STATUS_BAD_ADDR;
      end else if (full) begin
        res_status_r <= STATUS_FULL;
      end else begin
        res_status_r <= STATUS_DONE;
        res_had_r    <= (kind_r == KIND_ADD_DEC) && (fail_r != '0);
      end
    end
    if (cmd.get_issue) begin
      res_status_r <= sts.empty ? STATUS_EMPTY : STATUS_DONE;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(ram_rdata) * PROD_W'(eff_size);
    end
    if (cmd.sum) begin
      res_addr_r <= base_r + ADDR_W'(prod_r);
    end
    if (cmd.deliver) begin
      out_status         <= res_status_r;
      out_result_address <= res_addr_r;
      out_had_fails      <= res_had_r;
    end
  end

endmodule
`default_nettype wire

### rtl/iqsc_ctrl.sv
// Controller state machine that sequences the index queue datapath.
`default_nettype none
module iqsc_ctrl
  import iqsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_kind,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  state_t               state_r;
  state_t               state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_CNT_W-1:0] cnt_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 slot_free;

  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = (in_kind == KIND_GET || in_kind == KIND_GET_INC) ? ST_GET : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.add_commit = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_GET: begin
        cmd.get_issue = 1'b1;
        state_nxt     = sts.empty ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.deliver   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the index queue with its count of failed gets.
`default_nettype none
module testbench
  import iqsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] address;
    logic              had_fails;
  } queue_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BASE_ADDRESS;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_kind = KIND_ADD;
  logic [ADDR_W-1:0] in_entry_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_result_address;
  logic              out_had_fails;

  logic [ADDR_W-1:0]   pool_base = '0;
  logic [SIZE_W-1:0]   pool_entry_bytes = 16'd1;
  logic [CAP_LOG2-1:0] index_ring [DEPTH];
  logic [PTR_W-1:0]    ring_tail = '0;
  logic [PTR_W-1:0]    ring_head = '0;
  logic [FAIL_W-1:0]   failed_gets = '0;

  queue_result_t pending_results [$];
  queue_result_t want;
  int unsigned   in_idle_pct = 0;
  int unsigned   out_stall_pct = 0;
  int unsigned   hold_off_cycles = 0;
  int unsigned   error_count = 0;

  index_queue_with_stall_count i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_entry_address   (in_entry_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_had_fails      (out_had_fails)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic queue_result_t predict_queue_op(logic [1:0] kind,
                                                     logic [ADDR_W-1:0] addr);
    queue_result_t     r;
    logic [31:0]       unit_bytes;
    logic [31:0]       idx;
    logic [PTR_W-1:0]  fill;
    logic [63:0]       sum;
    r.status = STATUS_DONE;
    r.address = '0;
    r.had_fails = 1'b0;
    unit_bytes = (pool_entry_bytes == '0) ? 32'd1 : 32'(pool_entry_bytes);
    fill = ring_tail - ring_head;
    if (kind == KIND_ADD || kind == KIND_ADD_DEC) begin
      if (addr < pool_base) begin
        r.status = STATUS_BAD_ADDR;
      end else begin
        idx = (addr - pool_base) / unit_bytes;
        if (idx >= DEPTH) begin
          r.status = STATUS_BAD_ADDR;
        end else if (fill >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          index_ring[ring_tail[CAP_LOG2-1:0]] = idx[CAP_LOG2-1:0];
          ring_tail = ring_tail + 1'b1;
          if (kind == KIND_ADD_DEC && failed_gets != '0) begin
            failed_gets = failed_gets - 1'b1;
            r.had_fails = 1'b1;
          end
        end
      end
    end else if (fill == '0) begin
      r.status = STATUS_EMPTY;
      if (kind == KIND_GET_INC && failed_gets != FAIL_MAX) failed_gets = failed_gets + 1'b1;
    end else begin
      sum = 64'(pool_base) + 64'(index_ring[ring_head[CAP_LOG2-1:0]]) * 64'(unit_bytes);
      ring_head = ring_head + 1'b1;
      r.address = sum[31:0];
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pool_address(int unsigned idx);
    logic [63:0] a;
    logic [31:0] unit_bytes;
    unit_bytes = (pool_entry_bytes == '0) ? 32'd1 : 32'(pool_entry_bytes);
    a = 64'(pool_base) + 64'(idx) * 64'(unit_bytes) + 64'($urandom_range(unit_bytes - 1));
    return (a > 64'hFFFF_FFFF) ? $urandom() : a[31:0];
  endfunction

  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: status %0d, result_address %h",
               out_status, out_result_address);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_result_address !== want.address) begin
          $error("result_address: expected %h, got %h", want.address, out_result_address);
          error_count++;
        end
        if (out_had_fails !== want.had_fails) begin
          $error("had_fails: expected %0d, got %0d", want.had_fails, out_had_fails);
          error_count++;
        end
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_entry_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_queue_op(kind, addr));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] entry_bytes);
    drain_results();
    cfg_write_en <= 1'b1;
    cfg_index <= REG_BASE_ADDRESS;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= REG_ENTRY_BYTES;
    cfg_data <= 32'(entry_bytes);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    pool_base = base;
    pool_entry_bytes = entry_bytes;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [1:0]  kind;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(99);
    kind = (pick < 28) ? KIND_ADD : (pick < 52) ? KIND_ADD_DEC :
           (pick < 78) ? KIND_GET : KIND_GET_INC;
    pick = $urandom_range(99);
    if (kind == KIND_GET || kind == KIND_GET_INC || pick >= 93) begin
      addr = $urandom();
    end else if (pick < 78) begin
      addr = pool_address($urandom_range(DEPTH - 1));
    end else if (pick < 86) begin
      addr = pool_address($urandom_range(4 * DEPTH, DEPTH));
    end else begin
      addr = (pool_base == '0) ? $urandom() : $urandom_range(pool_base - 1, 0);
    end
    send_item(kind, addr);
  endtask

  task automatic test_basic_ops();
    set_config(32'h0, 16'd1);
    send_item(KIND_GET, 32'hFFFF_FFFF);
    send_item(KIND_GET_INC, 32'h0);
    send_item(KIND_GET_INC, 32'h0);
    send_item(KIND_ADD_DEC, 32'd5);
    send_item(KIND_ADD_DEC, 32'd0);
    send_item(KIND_ADD_DEC, 32'd1023);
    send_item(KIND_ADD, 32'd1024);
    send_item(KIND_ADD, 32'hFFFF_FFFF);
    send_item(KIND_GET, 32'h0);
    send_item(KIND_GET_INC, 32'h0);
    send_item(KIND_GET, 32'h0);
    send_item(KIND_GET, 32'h0);
  endtask

  task automatic test_config_extremes();
    set_config(32'h0000_1000, 16'd64);
    send_item(KIND_ADD, 32'h0000_0FFF);
    send_item(KIND_ADD, 32'h0000_1000 + 1023 * 64 + 63);
    send_item(KIND_ADD, 32'h0000_1000 + 1024 * 64);
    send_item(KIND_ADD_DEC, 32'h0000_1000 + 7 * 64 + 5);
    send_item(KIND_GET, 32'h0);
    send_item(KIND_GET, 32'h0);
    set_config(32'hFFFF_FFFF, 16'd0);
    send_item(KIND_ADD, 32'hFFFF_FFFF);
    send_item(KIND_ADD, 32'h0);
    send_item(KIND_GET, 32'h0);
    set_config(32'h0, 16'hFFFF);
    send_item(KIND_ADD, 32'd1023 * 32'd65535);
    send_item(KIND_ADD, 32'hFFFF_FFFF);
    set_config(32'hFFFF_FFFF, 16'hFFFF);
    send_item(KIND_GET, 32'h0);
  endtask

  task automatic test_full_queue();
    logic [PTR_W-1:0] fill;
    in_idle_pct = 27;
    out_stall_pct = 27;
    set_config(32'h2000_0000, 16'd16);
    fill = ring_tail - ring_head;
    repeat (fill) send_item(KIND_GET, $urandom());
    send_item(KIND_GET_INC, $urandom());
    send_item(KIND_GET_INC, $urandom());
    repeat (DEPTH) send_item(KIND_ADD, pool_address($urandom_range(DEPTH - 1)));
    send_item(KIND_ADD, pool_address(0));
    send_item(KIND_ADD_DEC, pool_address(DEPTH - 1));
    send_item(KIND_ADD_DEC, 32'h1FFF_FFFF);
    send_item(KIND_ADD, pool_address(DEPTH));
    repeat (4) send_item(KIND_GET, $urandom());
    send_item(KIND_ADD_DEC, pool_address(3));
    send_item(KIND_ADD_DEC, pool_address(5));
  endtask

  task automatic test_receiver_hold_off();
    in_idle_pct = 0;
    out_stall_pct = 0;
    set_config(32'h0400_0000, 16'd24);
    hold_off_cycles = 400;
    repeat (8) send_random_item();
    drain_results();
    repeat (8) send_random_item();
  endtask

  task automatic run_random_phase(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] entry_bytes,
                                  int unsigned idle_pct, int unsigned stall_pct);
    set_config(base, entry_bytes);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    repeat (30) send_random_item();
  endtask

  task automatic test_random_traffic();
    run_random_phase(32'h0, 16'd1, 0, 0);
    run_random_phase($urandom_range(32'h7FFF_FFFF), 16'($urandom_range(65535, 1)), 52, 0);
    run_random_phase(32'hFFFF_0000, 16'd48, 0, 52);
    run_random_phase(32'h1234_5670, 16'hFFFF, 27, 27);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_config_extremes();
    test_full_queue();
    test_receiver_hold_off();
    test_random_traffic();
    drain_results();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
